### design/tpdf_pkg.sv
// ----------------------------------------------------------------------------
// TCP port drop filter package
// Shared constants and types of the TCP destination port drop filter.
// ----------------------------------------------------------------------------
package tpdf_pkg;

    // Frame layout.
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] OFS_ETYPE_HI   = 16'd12;
    localparam logic [15:0] OFS_ETYPE_LO   = 16'd13;
    localparam logic [15:0] OFS_IP_IHL     = 16'd14;
    localparam logic [15:0] OFS_IP_PROTO   = 16'd23;
    localparam logic [15:0] OFS_DPORT_HI   = 16'd2;
    localparam logic [15:0] OFS_DPORT_LO   = 16'd3;
    localparam logic [15:0] OFS_TCP_DOFF   = 16'd12;

    // Header field values.
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

    localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;
    localparam logic [15:0] BLOCKED_PORT_RESET = 16'd80;

    // Verdict codes.
    localparam logic VERDICT_PASS = 1'b0;
    localparam logic VERDICT_DROP = 1'b1;

    localparam int DEF_QUEUE_DEPTH = 2;

    // One classified frame on its way from the parser to the counters.
    typedef struct packed {
        logic        verdict;
        logic [15:0] frame_length;
    } t_verdict;

endpackage

### design/tpdf_in_if.sv
// ----------------------------------------------------------------------------
// Frame byte channel
// Carries one frame byte per item with a last-byte mark.
// ----------------------------------------------------------------------------
interface tpdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### design/tpdf_out_if.sv
// ----------------------------------------------------------------------------
// Verdict channel
// Carries one verdict item per frame together with the updated counters.
// ----------------------------------------------------------------------------
interface tpdf_out_if;
    logic        valid;
    logic        ready;
    logic        verdict;
    logic [15:0] frame_length;
    logic [63:0] verdict_packet_count;
    logic [63:0] verdict_byte_count;

    modport source (
        output valid, output verdict, output frame_length,
        output verdict_packet_count, output verdict_byte_count, input ready
    );
    modport sink (
        input valid, input verdict, input frame_length,
        input verdict_packet_count, input verdict_byte_count, output ready
    );
endinterface

### design/tpdf_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries writes of the blocked destination port register.
// ----------------------------------------------------------------------------
interface tpdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] blocked_port;

    modport source (output valid, output blocked_port, input ready);
    modport sink   (input valid, input blocked_port, output ready);
endinterface

### design/tpdf_parser.sv
// ----------------------------------------------------------------------------
// TCP port drop filter parser
// Tracks the byte offset, captures the header fields and classifies a frame
// on its last byte.
// ----------------------------------------------------------------------------
module tpdf_parser
    import tpdf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    tpdf_in_if.sink      i_in,
    tpdf_cfg_if.sink     i_cfg,
    input  logic         i_q_not_full,
    output logic         o_q_push,
    output t_verdict     o_q_data
);

    logic [15:0] r_blocked_port;
    logic [15:0] r_offset;
    logic [15:0] r_ether_type;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [3:0]  r_doff;
    logic [15:0] r_dport;

    logic [15:0] n_ether_type;
    logic [3:0]  n_ihl;
    logic [7:0]  n_proto;
    logic [3:0]  n_doff;
    logic [15:0] n_dport;

    logic [15:0] tcp_start;
    logic [15:0] frame_len;
    logic [15:0] need_len;
    logic        accept;
    logic        drop;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_not_full;
    assign accept      = i_in.valid && i_in.ready;

    // The TCP header position uses the IHL captured before this byte.
    assign tcp_start = ETH_HDR_LEN + {10'd0, r_ihl, 2'b00};

    always_comb begin
        n_ether_type = r_ether_type;
        n_ihl        = r_ihl;
        n_proto      = r_proto;
        n_doff       = r_doff;
        n_dport      = r_dport;
        if (r_offset == OFS_ETYPE_HI) begin
            n_ether_type[15:8] = i_in.data_byte;
        end
        if (r_offset == OFS_ETYPE_LO) begin
            n_ether_type[7:0] = i_in.data_byte;
        end
        if (r_offset == OFS_IP_IHL) begin
            n_ihl = i_in.data_byte[3:0];
        end
        if (r_offset == OFS_IP_PROTO) begin
            n_proto = i_in.data_byte;
        end
        if (r_offset > OFS_IP_IHL) begin
            if (r_offset == tcp_start + OFS_DPORT_HI) begin
                n_dport[15:8] = i_in.data_byte;
            end
            if (r_offset == tcp_start + OFS_DPORT_LO) begin
                n_dport[7:0] = i_in.data_byte;
            end
            if (r_offset == tcp_start + OFS_TCP_DOFF) begin
                n_doff = i_in.data_byte[7:4];
            end
        end
    end

    assign frame_len = (r_offset == OFFSET_MAX) ? OFFSET_MAX : r_offset + 16'd1;
    assign need_len  = ETH_HDR_LEN + {10'd0, n_ihl, 2'b00} + {10'd0, n_doff, 2'b00};

    assign drop = (n_ether_type == ETHERTYPE_IPV4)
               && (n_ihl >= MIN_HDR_WORDS)
               && (n_proto == PROTO_TCP)
               && (n_doff >= MIN_HDR_WORDS)
               && (frame_len >= need_len)
               && (n_dport == r_blocked_port);

    assign o_q_push              = accept && i_in.last_byte;
    assign o_q_data.verdict      = drop ? VERDICT_DROP : VERDICT_PASS;
    assign o_q_data.frame_length = frame_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocked_port <= BLOCKED_PORT_RESET;
            r_offset       <= '0;
            r_ether_type   <= '0;
            r_ihl          <= '0;
            r_proto        <= '0;
            r_doff         <= '0;
            r_dport        <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_blocked_port <= i_cfg.blocked_port;
            end
            if (accept) begin
                if (i_in.last_byte) begin
                    r_offset     <= '0;
                    r_ether_type <= '0;
                    r_ihl        <= '0;
                    r_proto      <= '0;
                    r_doff       <= '0;
                    r_dport      <= '0;
                end else begin
                    r_ether_type <= n_ether_type;
                    r_ihl        <= n_ihl;
                    r_proto      <= n_proto;
                    r_doff       <= n_doff;
                    r_dport      <= n_dport;
                    if (r_offset != OFFSET_MAX) begin
                        r_offset <= r_offset + 16'd1;
                    end
                end
            end
        end
    end

endmodule

### design/tpdf_queue.sv
// ----------------------------------------------------------------------------
// TCP port drop filter verdict queue
// Small register queue between the parser and the counter unit.
// ----------------------------------------------------------------------------
module tpdf_queue
    import tpdf_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_verdict i_push_data,
    input  logic     i_pop,
    output logic     o_not_full,
    output logic     o_not_empty,
    output t_verdict o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_verdict         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_not_full  = (r_count != FULL_CNT);
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### design/tpdf_counter.sv
// ----------------------------------------------------------------------------
// TCP port drop filter counter unit
// Updates the per-verdict packet and byte counters and holds the result item.
// ----------------------------------------------------------------------------
module tpdf_counter
    import tpdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_not_empty,
    input  t_verdict   i_q_head,
    output logic       o_q_pop,
    tpdf_out_if.source o_out
);

    logic [1:0][63:0] r_pkt_cnt;
    logic [1:0][63:0] r_byte_cnt;
    logic             r_valid;
    logic             r_verdict;
    logic [15:0]      r_len;
    logic [63:0]      r_pkt_out;
    logic [63:0]      r_byte_out;

    logic [63:0] n_pkt;
    logic [63:0] n_byte;

    // A new verdict is taken whenever the output register is free or drains.
    assign o_q_pop = i_q_not_empty && (!r_valid || o_out.ready);

    assign n_pkt  = r_pkt_cnt[i_q_head.verdict] + 64'd1;
    assign n_byte = r_byte_cnt[i_q_head.verdict] + {48'd0, i_q_head.frame_length};

    assign o_out.valid                = r_valid;
    assign o_out.verdict              = r_verdict;
    assign o_out.frame_length         = r_len;
    assign o_out.verdict_packet_count = r_pkt_out;
    assign o_out.verdict_byte_count   = r_byte_out;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_verdict  <= i_q_head.verdict;
            r_len      <= i_q_head.frame_length;
            r_pkt_out  <= n_pkt;
            r_byte_out <= n_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pkt_cnt  <= '0;
            r_byte_cnt <= '0;
        end else begin
            if (o_q_pop) begin
                r_valid                         <= 1'b1;
                r_pkt_cnt[i_q_head.verdict]  <= n_pkt;
                r_byte_cnt[i_q_head.verdict] <= n_byte;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

### design/tcp_port_drop_filter_core.sv
// ----------------------------------------------------------------------------
// TCP port drop filter core
// Drops TCP/IPv4 frames whose destination port matches a configured port and
// keeps packet and byte counters per verdict.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle; the parser compares offsets and
// captures fields as each byte is accepted, and the counter unit retires one
// verdict per cycle while the output is taken. The input stalls only while
// the verdict queue is full. The verdict item for a frame is written into
// the queue when its last byte is accepted, then moved by the counter update
// into the output register once that register is free or drains.
// Reset: synchronous, active low; clears the parser state, the queue and all
// counters and sets the blocked port to 80. No clearing pass is needed.
// ----------------------------------------------------------------------------
module tcp_port_drop_filter_core
    import tpdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tpdf_in_if.sink    i_in,
    tpdf_cfg_if.sink   i_cfg,
    tpdf_out_if.source o_out
);

    // The front part is the parser. It takes one byte per cycle as long as
    // the verdict queue has room, so bytes keep flowing even while a verdict
    // waits for the downstream side to take it.
    logic     q_push;
    logic     q_pop;
    logic     q_not_full;
    logic     q_not_empty;
    t_verdict q_push_data;
    t_verdict q_head;

    tpdf_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .i_q_not_full (q_not_full),
        .o_q_push     (q_push),
        .o_q_data     (q_push_data)
    );

    // The queue decouples classification from counting. Only frame ends are
    // written into it, one entry per frame.
    tpdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_not_full  (q_not_full),
        .o_not_empty (q_not_empty),
        .o_head      (q_head)
    );

    // The back part updates the counter of the verdict and registers the
    // result item; it pops the queue whenever its output register is free or
    // is being emptied in the same cycle.
    tpdf_counter u_counter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_head      (q_head),
        .o_q_pop       (q_pop),
        .o_out         (o_out)
    );

endmodule
